// ===== rtl/slt_pkg.sv =====
// slot table allocator: shared types and command codes
// used by slt_key_ram, slt_match_unit and slot_table_allocator_core; no dependencies
package slt_pkg;

    localparam int KEY_W  = 16;
    localparam int TYPE_W = 8;
    localparam int ORD_W  = 5;
    localparam int CAP_W  = 5;
    localparam int SEL_W  = 4;

    typedef logic [1:0]        cmd_t;
    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [TYPE_W-1:0] type_t;

    localparam cmd_t CMD_ADD    = 2'd0;
    localparam cmd_t CMD_REMOVE = 2'd1;
    localparam cmd_t CMD_FIND   = 2'd2;
    localparam cmd_t CMD_NTH    = 2'd3;

    // compare outcome for one scanned slot
    typedef struct packed {
        logic hit;   // slot ends the scan
        logic cnt;   // slot counts toward the ordinal
    } match_t;

endpackage

// ===== rtl/slt_key_ram.sv =====
// key storage of the slot table: one write port, one registered read port
// depends on slt_pkg
module slt_key_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  slt_pkg::key_t     wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output slt_pkg::key_t     rd_data
);
    import slt_pkg::*;

    key_t key_mem [DEPTH];
    key_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= key_mem[rd_addr];
        end
    end

    assign rd_data = rdata_reg;

endmodule

// ===== rtl/slt_match_unit.sv =====
// shared slot compare unit: decides whether a scanned slot ends the scan and whether it counts toward the ordinal
// depends on slt_pkg
module slt_match_unit (
    input  slt_pkg::cmd_t   cmd,
    input  logic            occ,
    input  slt_pkg::key_t   slot_key,
    input  slt_pkg::key_t   item_key,
    input  slt_pkg::type_t  type_code,
    input  logic            last,
    output slt_pkg::match_t res
);
    import slt_pkg::*;

    logic key_eq;
    logic type_eq;

    assign key_eq  = (slot_key == item_key);
    assign type_eq = (slot_key[KEY_W-1:KEY_W-TYPE_W] == type_code);

    always_comb
    begin
        res = '0;
        unique case (cmd)
            CMD_ADD:
            begin
                res.hit = !occ;
            end
            CMD_FIND:
            begin
                res.hit = occ && key_eq;
            end
            CMD_NTH:
            begin
                res.cnt = occ && type_eq;
                res.hit = occ && type_eq && last;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

// ===== rtl/slot_table_allocator_core.sv =====
// slot table allocator top level: command sequencer, occupancy bits, scan control
// depends on slt_pkg, slt_key_ram, slt_match_unit
//
// usage
// - command channel: a transfer happens at a rising edge with start high and busy
//   low; cmd, item_key, slot_sel, type_code and ordinal are sampled then
// - result channel: done is high for exactly one cycle with ok, slot_out, key_out
//   and used_out valid; the receiver cannot stall, every result must be taken
// - config channel: cfg_capacity is written on cfg_valid && cfg_ready (ready is
//   always high); a write clears every occupied bit and the used count, and should
//   only be issued while the block is idle
// - completion: remove, full-table add, empty/zero-ordinal nth give done in the
//   cycle after the transfer; add, find and nth scan one slot per cycle, up to the
//   first min(capacity, SLOTS) slots, through the shared compare unit behind the
//   key ram read port
// - throughput: one command at a time; busy drops in the cycle done is shown, so
//   the next command can transfer in that same cycle
// - reset: capacity goes to 16, the table is empty; key storage is not cleared,
//   a key is only read back from an occupied slot
module slot_table_allocator_core #(
    parameter int SLOTS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // command channel
    input  logic                   start,
    output logic                   busy,
    input  slt_pkg::cmd_t          cmd,
    input  slt_pkg::key_t          item_key,
    input  logic [slt_pkg::SEL_W-1:0] slot_sel,
    input  slt_pkg::type_t         type_code,
    input  logic [slt_pkg::ORD_W-1:0] ordinal,
    // result channel
    output logic                   done,
    output logic                   ok,
    output logic [slt_pkg::SEL_W-1:0] slot_out,
    output slt_pkg::key_t          key_out,
    output logic [slt_pkg::CAP_W-1:0] used_out,
    // config channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [slt_pkg::CAP_W-1:0] cfg_capacity
);
    import slt_pkg::*;

    // index and count widths follow the slot count
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // sequencer states
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                 state_reg,    state_next;
    logic [CAP_W-1:0]     capacity_reg, capacity_next;
    logic [SLOTS-1:0]     occ_reg,      occ_next;
    logic [CNT_W-1:0]     used_reg,     used_next;

    // latched command
    cmd_t                 cmd_reg,      cmd_next;
    key_t                 ikey_reg,     ikey_next;
    type_t                type_reg,     type_next;
    logic [ORD_W-1:0]     left_reg,     left_next;

    // scan pointers: address issued and slot whose data is back
    logic [CNT_W-1:0]     scan_reg,     scan_next;
    logic                 pend_reg,     pend_next;
    logic [IDX_W-1:0]     pidx_reg,     pidx_next;

    // result registers
    logic                 done_reg,     done_next;
    logic                 ok_reg,       ok_next;
    logic [SEL_W-1:0]     slot_reg,     slot_next;
    key_t                 key_reg,      key_next;

    logic [CNT_W-1:0]     cap_use;
    logic [CMP_W-1:0]     sel_w;
    logic [IDX_W-1:0]     sel_idx;
    logic                 rm_ok;
    logic                 wr_en;
    logic                 rd_en;
    key_t                 rd_data;
    match_t               mres;

    // usable capacity saturates at the table size
    assign cap_use = (CMP_W'(capacity_reg) > CMP_W'(SLOTS)) ? CNT_W'(SLOTS)
                                                          : CNT_W'(capacity_reg);
    assign sel_w   = CMP_W'(slot_sel);
    assign sel_idx = sel_w[IDX_W-1:0];
    assign rm_ok   = (sel_w < CMP_W'(cap_use)) && occ_reg[sel_idx];

    slt_key_ram #(
        .DEPTH  (SLOTS),
        .ADDR_W (IDX_W)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (pidx_reg),
        .wr_data (ikey_reg),
        .rd_en   (rd_en),
        .rd_addr (scan_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // one compare per cycle on the slot whose key just came back
    slt_match_unit u_match (
        .cmd       (cmd_reg),
        .occ       (occ_reg[pidx_reg]),
        .slot_key  (rd_data),
        .item_key  (ikey_reg),
        .type_code (type_reg),
        .last      (left_reg == ORD_W'(1)),
        .res       (mres)
    );

    always_comb
    begin
        state_next    = state_reg;
        capacity_next = capacity_reg;
        occ_next      = occ_reg;
        used_next     = used_reg;
        cmd_next      = cmd_reg;
        ikey_next     = ikey_reg;
        type_next     = type_reg;
        left_next     = left_reg;
        scan_next     = scan_reg;
        pend_next     = pend_reg;
        pidx_next     = pidx_reg;
        done_next     = 1'b0;
        ok_next       = ok_reg;
        slot_next     = slot_reg;
        key_next      = key_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = cmd;
                    ikey_next = item_key;
                    type_next = type_code;
                    left_next = ordinal;
                    scan_next = '0;
                    pend_next = 1'b0;
                    ok_next   = 1'b0;
                    slot_next = '0;
                    key_next  = '0;
                    unique case (cmd)
                        CMD_ADD:
                        begin
                            if (used_reg < cap_use)
                            begin
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            done_next = 1'b1;
                            if (rm_ok)
                            begin
                                ok_next           = 1'b1;
                                occ_next[sel_idx] = 1'b0;
                                if (used_reg != '0)
                                begin
                                    used_next = used_reg - CNT_W'(1);
                                end
                            end
                        end
                        CMD_FIND:
                        begin
                            state_next = ST_SCAN;
                        end
                        CMD_NTH:
                        begin
                            if ((used_reg != '0) && (ordinal != '0))
                            begin
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                pend_next = 1'b0;
                if (pend_reg && mres.hit)
                begin
                    // slot found, close the scan
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    ok_next    = 1'b1;
                    if ((cmd_reg == CMD_ADD) || (cmd_reg == CMD_FIND))
                    begin
                        slot_next = SEL_W'(pidx_reg);
                    end
                    if (cmd_reg == CMD_NTH)
                    begin
                        key_next = rd_data;
                    end
                    if (cmd_reg == CMD_ADD)
                    begin
                        wr_en              = 1'b1;
                        occ_next[pidx_reg] = 1'b1;
                        used_next          = used_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    if (pend_reg && mres.cnt)
                    begin
                        left_next = left_reg - ORD_W'(1);
                    end
                    if (scan_reg < cap_use)
                    begin
                        rd_en     = 1'b1;
                        pend_next = 1'b1;
                        pidx_next = scan_reg[IDX_W-1:0];
                        scan_next = scan_reg + CNT_W'(1);
                    end
                    else
                    begin
                        // every usable slot checked without a hit
                        state_next = ST_IDLE;
                        done_next  = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // capacity write empties the table
        if (cfg_valid && cfg_ready)
        begin
            capacity_next = cfg_capacity;
            occ_next      = '0;
            used_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            capacity_reg <= CAP_W'(16);
            occ_reg      <= '0;
            used_reg     <= '0;
            scan_reg     <= '0;
            pend_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            capacity_reg <= capacity_next;
            occ_reg      <= occ_next;
            used_reg     <= used_next;
            scan_reg     <= scan_next;
            pend_reg     <= pend_next;
            done_reg     <= done_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        ikey_reg <= ikey_next;
        type_reg <= type_next;
        left_reg <= left_next;
        pidx_reg <= pidx_next;
        ok_reg   <= ok_next;
        slot_reg <= slot_next;
        key_reg  <= key_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign ok        = ok_reg;
    assign slot_out  = slot_reg;
    assign key_out   = key_reg;
    assign used_out  = CAP_W'(used_reg);

    // occupancy count never exceeds the usable capacity
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= cap_use)
        else $error("used count above usable capacity");

    // scan pointer stays within the usable slots
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_reg <= cap_use))
        else $error("scan pointer past usable capacity");

    // a failed command reports zero slot and key
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !ok_reg) |-> ((slot_reg == '0) && (key_reg == '0)))
        else $error("failed result carries slot or key");

    // an accepted command either finishes at once or starts a scan
    a_start_next: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done_reg || (state_reg == ST_SCAN)))
        else $error("accepted command neither done nor scanning");

endmodule

// ===== tb/slot_table_allocator_core_test.sv =====
// self-checking testbench for slot_table_allocator_core: directed and random table commands
// depends on slt_pkg and the slot_table_allocator_core rtl; shadow occupancy model checks each result
module slot_table_allocator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import slt_pkg::*;

    localparam int SLOT_COUNT = 16;
    // the watchdog limit covers every queued item with its idle gap many times over
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        cmd_t             cmd;
        key_t             key;
        logic [SEL_W-1:0] sel;
        type_t            typ;
        logic [ORD_W-1:0] ord;
    } slot_cmd_t;

    typedef struct packed {
        logic             ok;
        logic [SEL_W-1:0] slot;
        key_t             key;
        logic [CAP_W-1:0] used;
    } slot_reply_t;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // command channel
    logic             start = 1'b0;
    logic             busy;
    cmd_t             cmd = CMD_ADD;
    key_t             item_key = '0;
    logic [SEL_W-1:0] slot_sel = '0;
    type_t            type_code = '0;
    logic [ORD_W-1:0] ordinal = '0;

    // result channel
    logic             done;
    logic             ok;
    logic [SEL_W-1:0] slot_out;
    key_t             key_out;
    logic [CAP_W-1:0] used_out;

    // config channel
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_capacity = '0;

    // stimulus queue and outstanding replies
    slot_cmd_t   cmd_backlog[$];
    slot_reply_t owed_replies[$];

    // shadow of the allocator state
    logic             occ_shadow[SLOT_COUNT];
    key_t             key_shadow[SLOT_COUNT];
    int               used_shadow;
    logic [CAP_W-1:0] cap_shadow;

    // driver state
    slot_cmd_t next_cmd;
    int        gap_left;
    bit        idle_on = 1'b0;

    // monitor state
    slot_reply_t want;
    int          mismatches = 0;
    int          cycles = 0;

    // keys and types the random part draws from, so finds and nth lookups hit
    key_t key_menu[8];

    slot_table_allocator_core #(
        .SLOTS(SLOT_COUNT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .item_key    (item_key),
        .slot_sel    (slot_sel),
        .type_code   (type_code),
        .ordinal     (ordinal),
        .done        (done),
        .ok          (ok),
        .slot_out    (slot_out),
        .key_out     (key_out),
        .used_out    (used_out),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_capacity(cfg_capacity)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // capacity write empties the shadow table
    task automatic clear_shadow(input logic [CAP_W-1:0] cap);
        cap_shadow = cap;
        used_shadow = 0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            occ_shadow[i] = 1'b0;
            key_shadow[i] = '0;
        end
    endtask

    // apply one command to the shadow table and return the reply it gives
    function automatic slot_reply_t allocate_or_lookup(input slot_cmd_t c);
        slot_reply_t r;
        int          lim;
        int          left;
        bit          hit;
        int          i;
        r = '0;
        hit = 1'b0;
        // capacity above the slot count saturates
        lim = (cap_shadow > SLOT_COUNT) ? SLOT_COUNT : int'(cap_shadow);
        case (c.cmd)
            CMD_ADD:
            begin
                // a full table leaves everything as is
                if (used_shadow < lim)
                begin
                    for (i = 0; i < lim; i++)
                    begin
                        if (!hit && !occ_shadow[i])
                        begin
                            hit = 1'b1;
                            occ_shadow[i] = 1'b1;
                            key_shadow[i] = c.key;
                            used_shadow++;
                            r.ok = 1'b1;
                            r.slot = i[SEL_W-1:0];
                        end
                    end
                end
            end
            CMD_REMOVE:
            begin
                // slot at or above capacity or already free: no effect
                if (int'(c.sel) < lim && occ_shadow[c.sel])
                begin
                    occ_shadow[c.sel] = 1'b0;
                    if (used_shadow > 0)
                        used_shadow--;
                    r.ok = 1'b1;
                end
            end
            CMD_FIND:
            begin
                for (i = 0; i < lim; i++)
                begin
                    if (!hit && occ_shadow[i] && key_shadow[i] == c.key)
                    begin
                        hit = 1'b1;
                        r.ok = 1'b1;
                        r.slot = i[SEL_W-1:0];
                    end
                end
            end
            default:
            begin
                // empty table or ordinal zero never matches
                if (used_shadow != 0 && c.ord != 0)
                begin
                    left = int'(c.ord);
                    for (i = 0; i < lim; i++)
                    begin
                        if (!hit && occ_shadow[i] && key_shadow[i][KEY_W-1:8] == c.typ)
                        begin
                            left--;
                            if (left == 0)
                            begin
                                hit = 1'b1;
                                r.ok = 1'b1;
                                r.key = key_shadow[i];
                            end
                        end
                    end
                end
            end
        endcase
        r.used = used_shadow[CAP_W-1:0];
        return r;
    endfunction

    // driver: presents backlog items, with random idle bursts after a transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left <= 0;
        end
        else if (!start || !busy)
        begin
            // nothing presented, or the presented item transfers at this edge
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (cmd_backlog.size() != 0)
            begin
                next_cmd = cmd_backlog.pop_front();
                start <= 1'b1;
                cmd <= next_cmd.cmd;
                item_key <= next_cmd.key;
                slot_sel <= next_cmd.sel;
                type_code <= next_cmd.typ;
                ordinal <= next_cmd.ord;
                if (idle_on && $urandom_range(0, 4) == 0)
                    gap_left <= $urandom_range(1, 12);
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor: checks the reply of the oldest command first, then predicts a new transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (owed_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: reply with none outstanding: ok=%0d slot=%0d key=%h used=%0d",
                                 $realtime, ok, slot_out, key_out, used_out);
                end
                else
                begin
                    want = owed_replies.pop_front();
                    if (ok !== want.ok || slot_out !== want.slot ||
                        key_out !== want.key || used_out !== want.used)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("%0t: reply mismatch: exp ok=%0d slot=%0d key=%h used=%0d, got ok=%0d slot=%0d key=%h used=%0d",
                                     $realtime, want.ok, want.slot, want.key, want.used,
                                     ok, slot_out, key_out, used_out);
                    end
                end
            end
            if (start && !busy)
                owed_replies.push_back(allocate_or_lookup({cmd, item_key, slot_sel,
                                                           type_code, ordinal}));
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic queue_cmd(input cmd_t c, input key_t k, input int s, input type_t t,
                             input int o);
        slot_cmd_t item;
        item.cmd = c;
        item.key = k;
        item.sel = s[SEL_W-1:0];
        item.typ = t;
        item.ord = o[ORD_W-1:0];
        cmd_backlog.push_back(item);
    endtask

    // hold off until every outstanding reply is back and the block is idle
    task automatic wait_quiet();
        while (cmd_backlog.size() != 0 || owed_replies.size() != 0 || start)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_capacity <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        // write transfer took place at this edge
        cfg_valid <= 1'b0;
        clear_shadow(cap);
        @(negedge clk);
    endtask

    // one random command; fill mode leans toward adds, drain mode toward removes
    task automatic queue_random(input bit fill);
        int   pick;
        cmd_t c;
        key_t k;
        type_t t;
        int   o;
        pick = $urandom_range(0, 99);
        if (fill)
            c = (pick < 50) ? CMD_ADD : (pick < 62) ? CMD_REMOVE : (pick < 81) ? CMD_FIND : CMD_NTH;
        else
            c = (pick < 18) ? CMD_ADD : (pick < 60) ? CMD_REMOVE : (pick < 80) ? CMD_FIND : CMD_NTH;
        k = ($urandom_range(0, 4) == 0) ? key_t'($urandom) : key_menu[$urandom_range(0, 7)];
        t = ($urandom_range(0, 4) == 0) ? type_t'($urandom)
                                        : key_menu[$urandom_range(0, 7)][KEY_W-1:8];
        o = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
        queue_cmd(c, k, $urandom_range(0, 15), t, o);
    endtask

    task automatic run_phase(input logic [CAP_W-1:0] cap, input int count, input bit idle);
        bit fill;
        wait_quiet();
        write_capacity(cap);
        idle_on = idle;
        fill = 1'b1;
        for (int n = 0; n < count; n++)
        begin
            if (n % 16 == 0 && n != 0)
                fill = $urandom_range(0, 1);
            queue_random(fill);
        end
    endtask

    initial
    begin
        clear_shadow(CAP_W'(16));
        key_menu[0] = 16'h0000;
        key_menu[1] = 16'hFFFF;
        key_menu[2] = 16'hFF00;
        key_menu[3] = 16'h00FF;
        key_menu[4] = {8'h5A, 8'($urandom)};
        key_menu[5] = {8'h5A, 8'($urandom)};
        key_menu[6] = key_t'($urandom);
        key_menu[7] = {key_menu[6][KEY_W-1:8], 8'($urandom)};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part at the reset capacity of 16
        idle_on = 1'b1;
        queue_cmd(CMD_NTH, 16'h0000, 0, 8'h00, 1);     // empty table
        queue_cmd(CMD_ADD, 16'h0000, 0, 8'h00, 0);
        queue_cmd(CMD_ADD, 16'hFFFF, 15, 8'hFF, 31);
        queue_cmd(CMD_ADD, 16'h1234, 0, 8'h00, 0);
        queue_cmd(CMD_ADD, 16'hFF01, 0, 8'h00, 0);
        queue_cmd(CMD_FIND, 16'hFFFF, 0, 8'h00, 0);
        queue_cmd(CMD_FIND, 16'h5555, 0, 8'h00, 0);    // no match
        queue_cmd(CMD_NTH, 16'h0000, 0, 8'hFF, 1);
        queue_cmd(CMD_NTH, 16'h0000, 0, 8'hFF, 2);
        queue_cmd(CMD_NTH, 16'h0000, 0, 8'hFF, 3);     // no such slot
        queue_cmd(CMD_NTH, 16'h0000, 0, 8'hFF, 0);     // ordinal zero
        queue_cmd(CMD_NTH, 16'hFFFF, 15, 8'h12, 31);
        queue_cmd(CMD_REMOVE, 16'h0000, 1, 8'h00, 0);
        queue_cmd(CMD_REMOVE, 16'h0000, 1, 8'h00, 0);  // already free
        queue_cmd(CMD_REMOVE, 16'h0000, 15, 8'h00, 0); // never used
        queue_cmd(CMD_FIND, 16'hFFFF, 0, 8'h00, 0);
        queue_cmd(CMD_ADD, 16'hABCD, 0, 8'h00, 0);     // reuses the freed slot

        // small capacity: full table and remove at capacity
        wait_quiet();
        write_capacity(CAP_W'(2));
        queue_cmd(CMD_ADD, 16'h0102, 0, 8'h00, 0);
        queue_cmd(CMD_ADD, 16'h0304, 0, 8'h00, 0);
        queue_cmd(CMD_ADD, 16'h0506, 0, 8'h00, 0);     // table full
        queue_cmd(CMD_REMOVE, 16'h0000, 2, 8'h00, 0);  // at capacity
        queue_cmd(CMD_FIND, 16'h0304, 0, 8'h00, 0);

        // zero capacity: everything fails
        wait_quiet();
        write_capacity(CAP_W'(0));
        queue_cmd(CMD_ADD, 16'h7777, 0, 8'h00, 0);
        queue_cmd(CMD_REMOVE, 16'h0000, 0, 8'h00, 0);
        queue_cmd(CMD_FIND, 16'h7777, 0, 8'h00, 0);
        queue_cmd(CMD_NTH, 16'h0000, 0, 8'h77, 1);

        // random phases over several capacities, including saturation above 16
        run_phase(CAP_W'(16), 115, 1'b1);
        run_phase(CAP_W'(1), 110, 1'b1);
        run_phase(CAP_W'(31), 115, 1'b0);
        run_phase(CAP_W'(5), 110, 1'b1);
        run_phase(CAP_W'(0), 40, 1'b1);
        run_phase(CAP_W'(17), 115, 1'b1);
        run_phase(CAP_W'(3), 110, 1'b0);
        run_phase(CAP_W'(16), 115, 1'b1);
        run_phase(CAP_W'(8), 110, 1'b1);
        // closing stretch without idling
        run_phase(CAP_W'(16), 115, 1'b0);

        wait_quiet();
        repeat (30) @(negedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/slt_pkg.sv
rtl/slt_key_ram.sv
rtl/slt_match_unit.sv
rtl/slot_table_allocator_core.sv
tb/slot_table_allocator_core_test.sv
